// ===== design/tcf2ieee_pkg.sv =====
// ============================================================================
// tcf2ieee_pkg
// Shared constants, pipeline stage types and a helper function for the
// legacy two's complement float to IEEE 754 single precision converter.
// ============================================================================
package tcf2ieee_pkg;

    // Field widths of the legacy word and of the IEEE result.
    localparam int WordW  = 32;
    localparam int MantW  = 22;
    localparam int ExpW   = 9;
    localparam int ShiftW = 5;
    // Normalized exponent can go below zero, so it carries one extra sign bit.
    localparam int ExpNW  = ExpW + 1;

    // Exponent thresholds of the legacy format.
    localparam logic signed [ExpNW-1:0] ExpHigh   = 10'sd384;
    localparam logic signed [ExpNW-1:0] ExpLow    = 10'sd108;
    localparam logic signed [ExpNW-1:0] ExpNormal = 10'sd130;
    localparam logic signed [ExpNW-1:0] ExpExact  = 10'sd129;

    // IEEE exponent field of an infinity.
    localparam logic [7:0] IeeeExpInf = 8'hff;

    // Stage 1: sign split and magnitude.
    typedef struct packed {
        logic             sign;
        logic [ExpW-1:0]  expo;
        logic [MantW-1:0] mant;
        logic             last;
    } mag_stage_t;

    // Stage 2: leading zero count of the mantissa.
    typedef struct packed {
        logic              sign;
        logic [ExpW-1:0]   expo;
        logic [MantW-1:0]  mant;
        logic [ShiftW-1:0] lz;
        logic              zero;
        logic              last;
    } lzc_stage_t;

    // Stage 3: normalized mantissa and exponent.
    typedef struct packed {
        logic                    sign;
        logic signed [ExpNW-1:0] expo;
        logic [MantW-1:0]        mant;
        logic                    zero;
        logic                    last;
    } norm_stage_t;

    // Count of zero bits above the highest set bit of a nonzero mantissa.
    function automatic logic [ShiftW-1:0] lead_zeros(input logic [MantW-1:0] m);
        logic [ShiftW-1:0] n;
        n = '0;
        for (int i = 0; i < MantW; i++) begin
            if (m[i]) begin
                n = ShiftW'(MantW - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== design/twos_complement_float_to_ieee_single_top.sv =====
// ============================================================================
// twos_complement_float_to_ieee_single_top
// Converts a stream of 32-bit legacy floats (two's complement by sign, 9-bit
// exponent, 22-bit mantissa with no hidden bit) to IEEE 754 single words.
// ============================================================================
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata, s_tlast) takes one legacy
//   word per transfer; the master channel (m_tvalid, m_tready, m_tdata,
//   m_tlast) returns one IEEE single word per transfer, in input order, with
//   tlast copied from the matching input.
//   The converter is a four stage pipeline: magnitude, leading zero count,
//   normalize, classify and pack. Each word is registered in every stage in
//   turn and appears on the master side from the output register, and one
//   word is taken every cycle while the receiver keeps m_tready high.
//   Each stage holds a valid bit and loads whenever it is empty or the stage
//   after it moves on, so a stall of m_tready fills the empty stages first
//   and s_tready drops only when all four hold a word; nothing is dropped or
//   repeated.
//   aresetn is synchronous and active low; it empties the pipeline. The
//   mantissa is truncated, large exponents give a signed infinity and small
//   ones a signed zero.
// ============================================================================
module twos_complement_float_to_ieee_single_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Slave side
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tcf2ieee_pkg::WordW-1:0] s_tdata,  // [31:0] legacy_word
    input  logic                       s_tlast,      // block_end
    // Master side
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tcf2ieee_pkg::WordW-1:0] m_tdata,  // [31:0] ieee_word
    output logic                       m_tlast       // block_end_out
);
    import tcf2ieee_pkg::*;

    // Stage valid bits and payload registers.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    mag_stage_t  st1_reg, st1_next;
    lzc_stage_t  st2_reg, st2_next;
    norm_stage_t st3_reg, st3_next;
    logic [WordW-1:0] out_reg, out_next;
    logic             out_last_reg;

    // A stage may load when it is empty or its content moves on this cycle.
    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: take the sign and negate negative words to their magnitude.
    logic [WordW-1:0] mag;
    always_comb begin
        mag = s_tdata[WordW-1] ? (WordW'(0) - s_tdata) : s_tdata;
        st1_next.sign = s_tdata[WordW-1];
        st1_next.expo = mag[MantW +: ExpW];
        st1_next.mant = mag[MantW-1:0];
        st1_next.last = s_tlast;
    end

    // Stage 2: count the leading zeros of the mantissa.
    always_comb begin
        st2_next.sign = st1_reg.sign;
        st2_next.expo = st1_reg.expo;
        st2_next.mant = st1_reg.mant;
        st2_next.lz   = lead_zeros(st1_reg.mant);
        st2_next.zero = (st1_reg.mant == '0);
        st2_next.last = st1_reg.last;
    end

    // Stage 3: shift the mantissa up and lower the exponent by the same count.
    always_comb begin
        st3_next.sign = st2_reg.sign;
        st3_next.expo = $signed({1'b0, st2_reg.expo})
                      - $signed({{(ExpNW-ShiftW){1'b0}}, st2_reg.lz});
        st3_next.mant = st2_reg.mant << st2_reg.lz;
        st3_next.zero = st2_reg.zero;
        st3_next.last = st2_reg.last;
    end

    // Stage 4: classify the exponent and pack the IEEE word.
    logic [ExpNW-1:0]  biased;
    logic [ExpNW-1:0]  sub_diff;
    logic [ShiftW-1:0] sub_sh;
    always_comb begin
        biased   = st3_reg.expo - ExpNormal;
        sub_diff = ExpExact - st3_reg.expo;
        sub_sh   = sub_diff[ShiftW-1:0];
        out_next = {st3_reg.sign, {(WordW-1){1'b0}}};
        if (st3_reg.zero || st3_reg.expo < ExpLow) begin
            out_next = {st3_reg.sign, {(WordW-1){1'b0}}};
        end else if (st3_reg.expo > ExpHigh) begin
            out_next = {st3_reg.sign, IeeeExpInf, 23'd0};
        end else if (st3_reg.expo > ExpNormal) begin
            out_next = {st3_reg.sign, biased[7:0], st3_reg.mant[MantW-2:0], 2'b00};
        end else if (st3_reg.expo == ExpNormal) begin
            out_next = {st3_reg.sign, 8'd0, st3_reg.mant, 1'b0};
        end else if (st3_reg.expo == ExpExact) begin
            out_next = {st3_reg.sign, 9'd0, st3_reg.mant};
        end else begin
            out_next = {st3_reg.sign, 9'd0, st3_reg.mant >> sub_sh};
        end
    end

    // Valid bits follow the loads of each stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Payload registers load together with a valid word from the stage before.
    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) st1_reg <= st1_next;
        if (rdy2 && v1_reg)   st2_reg <= st2_next;
        if (rdy3 && v2_reg)   st3_reg <= st3_next;
        if (rdy4 && v3_reg) begin
            out_reg      <= out_next;
            out_last_reg <= st3_reg.last;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

endmodule
